// File: design/assert_macros.svh
// assertion macros for the design files, included by the top-level lexer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define SLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset too
`define SLT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/slt_pkg.sv
// types, constants and character helpers of the source lexer
package slt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int CFG_BITS        = 5;
    localparam int KIND_BITS       = 5;
    localparam int LEN_BITS        = 8;
    localparam int OUT_LINE_BITS   = 16;
    localparam int OUT_OFF_BITS    = 24;
    localparam int TDATA_BITS      = 72;
    localparam logic [CFG_BITS-1:0] TAB_WIDTH_RST = 5'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [KIND_BITS-1:0] {
        K_IDENT    = 5'd0,
        K_FUNC     = 5'd1,
        K_RETURN   = 5'd2,
        K_DIVIDE   = 5'd3,
        K_MINUS    = 5'd4,
        K_ARROW    = 5'd5,
        K_PLUS     = 5'd6,
        K_MULTIPLY = 5'd7,
        K_MODULO   = 5'd8,
        K_COMMA    = 5'd9,
        K_SEMI     = 5'd10,
        K_LCURLY   = 5'd11,
        K_RCURLY   = 5'd12,
        K_LPAREN   = 5'd13,
        K_RPAREN   = 5'd14,
        K_END      = 5'd15,
        K_ERROR    = 5'd16
    } tok_kind_t;

    // one lexer pass as seen by the datapath
    typedef struct packed {
        logic      adv_char;
        logic      adv_line;
        logic      adv_tab;
        logic      mark;
        logic      emit;
        tok_kind_t kind;
        logic      last;
    } lex_cmd_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] cur_len;
        logic                div_busy;
        logic                out_free;
    } lex_stat_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic tok_kind_t single_kind(input logic [7:0] c);
        tok_kind_t k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2A:   k = K_MULTIPLY;
            8'h25:   k = K_MODULO;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_SEMI;
            8'h7B:   k = K_LCURLY;
            8'h7D:   k = K_RCURLY;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // true when the start mode emits a token for this byte
    function automatic logic start_emits(input logic [7:0] c);
        return !(is_alpha(c) || c == CH_LF || c == CH_CR || c == CH_TAB
                 || c == CH_SPACE || c == CH_SLASH || c == CH_MINUS);
    endfunction

    function automatic logic [7:0] kw_func_char(input logic [LEN_BITS-1:0] p);
        logic [7:0] ch;
        case (p)
            8'd0:    ch = 8'h66;
            8'd1:    ch = 8'h75;
            8'd2:    ch = 8'h6E;
            8'd3:    ch = 8'h63;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_return_char(input logic [LEN_BITS-1:0] p);
        logic [7:0] ch;
        case (p)
            8'd0:    ch = 8'h72;
            8'd1:    ch = 8'h65;
            8'd2:    ch = 8'h74;
            8'd3:    ch = 8'h75;
            8'd4:    ch = 8'h72;
            8'd5:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: design/source_lexer_tokenizer.sv
// byte-stream lexer: one byte per transaction in, tokens out with start position
// a token is presented in the cycle after the pass that closes it
// a byte is accepted, then takes one or two lexer passes, plus output waits
// a tab also stalls input while the bit-serial tab stop remainder unit runs
// throughput: at most two tokens per byte and one per cycle out, while m_tready is high
// reset: synchronous active-low aresetn clears mode, counters and tab width (to 2)
`include "assert_macros.svh"

module source_lexer_tokenizer #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [slt_pkg::CFG_BITS-1:0]   cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // char_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // token_kind, start_line, start_column, start_offset, lexeme_length, zero pad
    output logic [slt_pkg::TDATA_BITS-1:0] m_tdata,
    output logic                           m_tlast   // last_of_run
);

    slt_pkg::lex_cmd_t  cmd;
    slt_pkg::lex_stat_t stat;

    slt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .cmd      (cmd)
    );

    slt_dpath #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    `SLT_ASSERT(a_no_take_while_div, stat.div_busy |-> !s_tready, "byte taken during tab divide")
    `SLT_ASSERT(a_hold_after_take, (s_tvalid && s_tready) |=> !s_tready, "second byte taken")
    `SLT_ASSERT(a_emit_needs_room, cmd.emit |-> stat.out_free, "token emitted over full output")
    `SLT_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

// File: design/slt_ctrl.sv
// lexer FSM: holds the byte, one pass per cycle unless output/tab stall
module slt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  slt_pkg::lex_stat_t stat,
    output slt_pkg::lex_cmd_t  cmd
);

    typedef enum logic [8:0] {
        M_START    = 9'b000000001,
        M_CR       = 9'b000000010,
        M_DIV      = 9'b000000100,
        M_IDENT    = 9'b000001000,
        M_MINUS    = 9'b000010000,
        M_MLC      = 9'b000100000,
        M_MLC_CR   = 9'b001000000,
        M_MLC_STAR = 9'b010000000,
        M_SLC      = 9'b100000000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [1:0] kw_reg, kw_next;
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg;
    logic       done;
    logic       step;
    logic       later_emit;
    slt_pkg::lex_cmd_t cmd_c;

    assign s_tready   = !byte_valid_reg && !stat.div_busy;
    assign step       = byte_valid_reg && stat.out_free && !stat.div_busy;
    assign later_emit = slt_pkg::start_emits(byte_reg);
    assign cmd        = step ? cmd_c : '0;

    always_comb begin
        cmd_c     = '0;
        cmd_c.kind = slt_pkg::K_IDENT;
        done      = 1'b0;
        mode_next = mode_reg;
        kw_next   = kw_reg;
        unique case (mode_reg)
            M_CR: begin
                if (byte_reg == slt_pkg::CH_LF) begin
                    cmd_c.adv_char = 1'b1;
                    done = 1'b1;
                end
                cmd_c.adv_line = 1'b1;
                mode_next = M_START;
            end
            M_DIV: begin
                if (byte_reg == slt_pkg::CH_SLASH) begin
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_SLC;
                    done = 1'b1;
                end else if (byte_reg == slt_pkg::CH_STAR) begin
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_MLC;
                    done = 1'b1;
                end else begin
                    cmd_c.emit = 1'b1;
                    cmd_c.kind = slt_pkg::K_DIVIDE;
                    cmd_c.last = !later_emit;
                    mode_next = M_START;
                end
            end
            M_IDENT: begin
                if (slt_pkg::is_alnum(byte_reg)) begin
                    if (!(stat.cur_len < 8'd4 &&
                          slt_pkg::kw_func_char(stat.cur_len) == byte_reg)) begin
                        kw_next[0] = 1'b0;
                    end
                    if (!(stat.cur_len < 8'd6 &&
                          slt_pkg::kw_return_char(stat.cur_len) == byte_reg)) begin
                        kw_next[1] = 1'b0;
                    end
                    cmd_c.adv_char = 1'b1;
                    done = 1'b1;
                end else begin
                    cmd_c.emit = 1'b1;
                    cmd_c.last = !later_emit;
                    if (kw_reg[0] && stat.cur_len == 8'd4) begin
                        cmd_c.kind = slt_pkg::K_FUNC;
                    end else if (kw_reg[1] && stat.cur_len == 8'd6) begin
                        cmd_c.kind = slt_pkg::K_RETURN;
                    end else begin
                        cmd_c.kind = slt_pkg::K_IDENT;
                    end
                    kw_next   = 2'b11;
                    mode_next = M_START;
                end
            end
            M_MINUS: begin
                cmd_c.emit = 1'b1;
                if (byte_reg == slt_pkg::CH_GT) begin
                    cmd_c.adv_char = 1'b1;
                    cmd_c.kind = slt_pkg::K_ARROW;
                    cmd_c.last = 1'b1;
                    done = 1'b1;
                end else begin
                    cmd_c.kind = slt_pkg::K_MINUS;
                    cmd_c.last = !later_emit;
                end
                mode_next = M_START;
            end
            M_MLC: begin
                done = 1'b1;
                if (byte_reg == slt_pkg::CH_NUL) begin
                    cmd_c.mark = 1'b1;
                    cmd_c.emit = 1'b1;
                    cmd_c.kind = slt_pkg::K_END;
                    cmd_c.last = 1'b1;
                    mode_next = M_START;
                end else begin
                    cmd_c.adv_char = 1'b1;
                    if (byte_reg == slt_pkg::CH_LF) begin
                        cmd_c.adv_line = 1'b1;
                    end else if (byte_reg == slt_pkg::CH_CR) begin
                        mode_next = M_MLC_CR;
                    end else if (byte_reg == slt_pkg::CH_STAR) begin
                        mode_next = M_MLC_STAR;
                    end
                end
            end
            M_MLC_CR: begin
                if (byte_reg == slt_pkg::CH_LF) begin
                    cmd_c.adv_char = 1'b1;
                    done = 1'b1;
                end
                cmd_c.adv_line = 1'b1;
                mode_next = M_MLC;
            end
            M_MLC_STAR: begin
                if (byte_reg == slt_pkg::CH_SLASH) begin
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_START;
                    done = 1'b1;
                end else begin
                    mode_next = M_MLC;
                end
            end
            M_SLC: begin
                done = 1'b1;
                if (byte_reg == slt_pkg::CH_NUL) begin
                    cmd_c.mark = 1'b1;
                    cmd_c.emit = 1'b1;
                    cmd_c.kind = slt_pkg::K_END;
                    cmd_c.last = 1'b1;
                    mode_next = M_START;
                end else begin
                    cmd_c.adv_char = 1'b1;
                    if (byte_reg == slt_pkg::CH_LF) begin
                        cmd_c.adv_line = 1'b1;
                        mode_next = M_START;
                    end else if (byte_reg == slt_pkg::CH_CR) begin
                        mode_next = M_CR;
                    end
                end
            end
            default: begin
                cmd_c.mark = 1'b1;
                done = 1'b1;
                mode_next = M_START;
                if (slt_pkg::is_alpha(byte_reg)) begin
                    kw_next = {byte_reg == 8'h72, byte_reg == 8'h66};
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_IDENT;
                end else if (byte_reg == slt_pkg::CH_NUL) begin
                    cmd_c.emit = 1'b1;
                    cmd_c.kind = slt_pkg::K_END;
                    cmd_c.last = 1'b1;
                end else if (byte_reg == slt_pkg::CH_LF) begin
                    cmd_c.adv_char = 1'b1;
                    cmd_c.adv_line = 1'b1;
                end else if (byte_reg == slt_pkg::CH_CR) begin
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_CR;
                end else if (byte_reg == slt_pkg::CH_TAB) begin
                    cmd_c.adv_char = 1'b1;
                    cmd_c.adv_tab  = 1'b1;
                end else if (byte_reg == slt_pkg::CH_SPACE) begin
                    cmd_c.adv_char = 1'b1;
                end else if (byte_reg == slt_pkg::CH_SLASH) begin
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_DIV;
                end else if (byte_reg == slt_pkg::CH_MINUS) begin
                    cmd_c.adv_char = 1'b1;
                    mode_next = M_MINUS;
                end else begin
                    cmd_c.adv_char = 1'b1;
                    cmd_c.emit = 1'b1;
                    cmd_c.kind = slt_pkg::single_kind(byte_reg);
                    cmd_c.last = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        byte_valid_next = byte_valid_reg;
        if (s_tvalid && s_tready) begin
            byte_valid_next = 1'b1;
        end else if (step && done) begin
            byte_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_START;
            kw_reg         <= 2'b11;
            byte_valid_reg <= 1'b0;
        end else begin
            byte_valid_reg <= byte_valid_next;
            if (step) begin
                mode_reg <= mode_next;
                kw_reg   <= kw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// File: design/slt_dpath.sv
// position counters, tab divider and token output register
module slt_dpath #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [slt_pkg::CFG_BITS-1:0]     cfg_wr_data,
    input  slt_pkg::lex_cmd_t                cmd,
    output slt_pkg::lex_stat_t               stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [slt_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int VBITS = LINE_BITS + 1;
    localparam int CBITS = $clog2(VBITS + 1);
    localparam int LW = (LINE_BITS > slt_pkg::OUT_LINE_BITS) ? LINE_BITS
                                                               : slt_pkg::OUT_LINE_BITS;
    localparam int OW = (OFFSET_BITS > slt_pkg::OUT_OFF_BITS) ? OFFSET_BITS
                                                                : slt_pkg::OUT_OFF_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    logic [slt_pkg::CFG_BITS-1:0] tab_width_reg;
    logic [OFFSET_BITS-1:0] off_reg, off_next, tso_reg;
    logic [LINE_BITS-1:0]   line_reg, line_next, col_reg, col_next, col_inc;
    logic [LINE_BITS-1:0]   tsl_reg, tsc_reg;
    logic [slt_pkg::CFG_BITS-1:0] tw;

    logic [VBITS-1:0] vsh_reg, vhold_reg, vstart, vres;
    logic [slt_pkg::CFG_BITS-1:0] rem_reg, rem_next;
    logic [slt_pkg::CFG_BITS:0]   r2;
    logic [CBITS-1:0] cnt_reg;

    logic [OFFSET_BITS-1:0] st_off, len_diff, cur_diff;
    logic [LINE_BITS-1:0]   st_line, st_col;
    logic [LW-1:0] line_ext, col_ext;
    logic [OW-1:0] off_ext;
    logic [15:0] o_line, o_col;
    logic [23:0] o_off;
    logic [7:0]  o_len;

    logic                          m_tvalid_reg;
    logic [slt_pkg::TDATA_BITS-1:0] m_tdata_reg;
    logic                          m_tlast_reg;

    assign tw      = (tab_width_reg == '0) ? slt_pkg::CFG_BITS'(1) : tab_width_reg;
    assign col_inc = (col_reg == LINE_MAX) ? col_reg : col_reg + 1'b1;
    assign vstart  = {1'b0, col_inc} + VBITS'(tw);

    always_comb begin
        off_next = off_reg;
        if (cmd.adv_char && off_reg != OFF_MAX) begin
            off_next = off_reg + 1'b1;
        end
    end

    // restoring remainder step, one bit per cycle
    assign r2       = {rem_reg, vsh_reg[VBITS-1]};
    assign rem_next = (r2 >= {1'b0, tw}) ? slt_pkg::CFG_BITS'(r2 - {1'b0, tw})
                                         : r2[slt_pkg::CFG_BITS-1:0];
    assign vres     = vhold_reg - VBITS'(rem_next);

    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        if (cmd.adv_char) begin
            col_next = col_inc;
        end
        if (cmd.adv_line) begin
            col_next = LINE_BITS'(1);
            if (line_reg != LINE_MAX) begin
                line_next = line_reg + 1'b1;
            end
        end
        if (cnt_reg == CBITS'(1)) begin
            col_next = (vres[VBITS-1]) ? LINE_MAX : vres[LINE_BITS-1:0];
        end
    end

    assign cur_diff = (off_reg >= tso_reg) ? off_reg - tso_reg : '0;
    assign stat.cur_len  = (cur_diff > OFFSET_BITS'(255)) ? 8'hFF : cur_diff[7:0];
    assign stat.div_busy = (cnt_reg != '0);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign st_off   = cmd.mark ? off_reg  : tso_reg;
    assign st_line  = cmd.mark ? line_reg : tsl_reg;
    assign st_col   = cmd.mark ? col_reg  : tsc_reg;
    assign len_diff = (off_next >= st_off) ? off_next - st_off : '0;
    assign line_ext = LW'(st_line);
    assign col_ext  = LW'(st_col);
    assign off_ext  = OW'(st_off);
    assign o_line = (line_ext > LW'(16'hFFFF)) ? 16'hFFFF : line_ext[15:0];
    assign o_col  = (col_ext > LW'(16'hFFFF)) ? 16'hFFFF : col_ext[15:0];
    assign o_off  = (off_ext > OW'(24'hFFFFFF)) ? 24'hFFFFFF : off_ext[23:0];
    assign o_len  = (len_diff > OFFSET_BITS'(255)) ? 8'hFF : len_diff[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg <= slt_pkg::TAB_WIDTH_RST;
            off_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            col_reg  <= LINE_BITS'(1);
            tso_reg  <= '0;
            tsl_reg  <= LINE_BITS'(1);
            tsc_reg  <= LINE_BITS'(1);
            cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tab_width_reg <= cfg_wr_data;
            end
            off_reg  <= off_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            if (cmd.mark) begin
                tso_reg <= off_reg;
                tsl_reg <= line_reg;
                tsc_reg <= col_reg;
            end
            if (cmd.adv_tab) begin
                cnt_reg <= CBITS'(VBITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.adv_tab) begin
            vsh_reg   <= vstart;
            vhold_reg <= vstart;
            rem_reg   <= '0;
        end else if (cnt_reg != '0) begin
            vsh_reg <= {vsh_reg[VBITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {3'b000, o_len, o_off, o_col, o_line, cmd.kind};
            m_tlast_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
